### rtl/rpn_pkg.sv
// Shared types and constants for the RPN stack calculator.
// Holds token and status codes, port widths and the multiply/divide
// control struct. No dependencies.
package rpn_pkg;

  // Port field widths, fixed by the item format
  localparam int ACTION_W    = 4;
  localparam int IN_VAL_W    = 32;
  localparam int OUT_TOP_W   = 32;
  localparam int OUT_DEPTH_W = 5;
  localparam int STATUS_W    = 3;

  // Default sizing of the operand stack
  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  // Token actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH    = 4'd0,
    ACT_ADD     = 4'd1,
    ACT_SUB     = 4'd2,
    ACT_MUL     = 4'd3,
    ACT_DIV     = 4'd4,
    ACT_DROP    = 4'd5,
    ACT_SWAP    = 4'd6,
    ACT_DUP     = 4'd7,
    ACT_UNKNOWN = 4'd8
  } action_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FEW     = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_FULL    = 3'd3,
    ST_DIVZERO = 3'd4
  } status_t;

  // Request to the shared multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;

endpackage

### rtl/rpn_if.sv
// Valid/ready channel interfaces for the RPN calculator token and result items.
// Depends on rpn_pkg for the field widths.
interface rpn_in_if;
  logic                           valid;
  logic                           ready;
  logic [rpn_pkg::ACTION_W-1:0]   action;
  logic signed [rpn_pkg::IN_VAL_W-1:0] operand_value;

  modport source (output valid, output action, output operand_value, input ready);
  modport sink   (input valid, input action, input operand_value, output ready);
endinterface

interface rpn_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rpn_pkg::OUT_TOP_W-1:0] top_value;
  logic [rpn_pkg::OUT_DEPTH_W-1:0]   stack_depth;
  logic [rpn_pkg::STATUS_W-1:0]      status;

  modport source (output valid, output top_value, output stack_depth, output status,
                  input ready);
  modport sink   (input valid, input top_value, input stack_depth, input status,
                  output ready);
endinterface

### rtl/rpn_muldiv.sv
// Iterative multiply and signed divide, one bit per cycle, DATA_WIDTH steps.
// Multiply keeps the low DATA_WIDTH bits; divide truncates toward zero.
// Depends on rpn_pkg for md_ctrl_t.
module rpn_muldiv #(
  parameter int DATA_WIDTH = rpn_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rpn_pkg::md_ctrl_t     ctrl_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] result_o
);
  import rpn_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  div_r, div_nxt;
  logic                  neg_r, neg_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] x_r, x_nxt;
  logic [DATA_WIDTH-1:0] y_r, y_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;

  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   rem_sub;
  logic                  rem_ge;
  logic [DATA_WIDTH-1:0] mag_a, mag_b;

  // Operand magnitudes for the divide
  assign mag_a = a_i[DATA_WIDTH-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[DATA_WIDTH-1] ? (~b_i + 1'b1) : b_i;

  // One restoring divide step: shift in the next dividend bit and try subtracting
  assign rem_sh  = {acc_r, x_r[DATA_WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, y_r};
  assign rem_ge  = (rem_sh >= {1'b0, y_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    if (ctrl_i.start) begin
      // Load operands and arm the step counter
      busy_nxt = 1'b1;
      div_nxt  = ctrl_i.is_div;
      neg_nxt  = a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
      cnt_nxt  = CNT_W'(DATA_WIDTH);
      x_nxt    = ctrl_i.is_div ? mag_a : a_i;
      y_nxt    = ctrl_i.is_div ? mag_b : b_i;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (div_r) begin
        acc_nxt = rem_ge ? rem_sub[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
        x_nxt   = {x_r[DATA_WIDTH-2:0], rem_ge};
      end else begin
        // Shift-add: add the shifted multiplicand for each set multiplier bit
        acc_nxt = y_r[0] ? (acc_r + x_r) : acc_r;
        x_nxt   = {x_r[DATA_WIDTH-2:0], 1'b0};
        y_nxt   = {1'b0, y_r[DATA_WIDTH-1:1]};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

  // Fix the quotient sign; the product sits in the accumulator
  assign done_o   = done_r;
  assign result_o = div_r ? (neg_r ? (~x_r + 1'b1) : x_r) : acc_r;

endmodule

### rtl/rpn_stack_calculator_unit.sv
// RPN integer stack calculator: one token item in, one result item out.
// Each accepted token passes through S_EXEC and S_EMIT; swap adds S_SWAP for its second
// write to the single-port stack, mul and div add S_ARITH for the shared one-bit-a-step unit.
// Items are taken one at a time: a new token is accepted only back in S_IDLE, after
// the result has been loaded into the output register.
// Synchronous active-low reset empties the stack; stack memory contents are not cleared.
module rpn_stack_calculator_unit #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = rpn_pkg::DATA_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rpn_in_if.sink    in_ch,
  rpn_out_if.source out_ch
);
  import rpn_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWAP,
    S_ARITH,
    S_EMIT
  } state_t;

  // Operand stack storage
  logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  action_t                act_r;
  logic [DATA_WIDTH-1:0]  opnd_r;
  logic [DATA_WIDTH-1:0]  rd_top_r, rd_next_r;
  logic [DATA_WIDTH-1:0]  res_top_r, res_top_nxt;
  status_t                res_stat_r, res_stat_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TOP_W-1:0]   out_top_r, out_top_nxt;
  logic [OUT_DEPTH_W-1:0] out_depth_r, out_depth_nxt;
  status_t                out_stat_r, out_stat_nxt;

  logic                   in_fire;
  logic [AW-1:0]          ra_top, ra_next;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [DATA_WIDTH-1:0]  wdata;
  logic                   has1, has2, full;
  logic [DATA_WIDTH-1:0]  top_keep;
  logic [DATA_WIDTH-1:0]  addsub;
  md_ctrl_t               md_ctrl;
  logic                   md_done;
  logic [DATA_WIDTH-1:0]  md_result;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Top and next-to-top addresses
  assign ra_top  = AW'(cnt_r - CW'(1));
  assign ra_next = AW'(cnt_r - CW'(2));

  assign has1     = (cnt_r != '0);
  assign has2     = (cnt_r > CW'(1));
  assign full     = (cnt_r == CW'(STACK_DEPTH));
  assign top_keep = has1 ? rd_top_r : '0;
  assign addsub   = (act_r == ACT_ADD) ? (rd_next_r + rd_top_r) : (rd_next_r - rd_top_r);

  // Shared multiply/divide, left operand is next-to-top
  rpn_muldiv #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_i   (md_ctrl),
    .a_i      (rd_next_r),
    .b_i      (rd_top_r),
    .done_o   (md_done),
    .result_o (md_result)
  );

  // Write back and read both top entries when an item is taken
  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[waddr] <= wdata;
    end
    if (in_fire) begin
      rd_top_r  <= stack_mem[ra_top];
      rd_next_r <= stack_mem[ra_next];
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    res_top_nxt   = res_top_r;
    res_stat_nxt  = res_stat_r;
    we            = 1'b0;
    waddr         = cnt_r[AW-1:0];
    wdata         = opnd_r;
    md_ctrl       = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_top_nxt   = out_top_r;
    out_depth_nxt = out_depth_r;
    out_stat_nxt  = out_stat_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_top_nxt  = top_keep;
        res_stat_nxt = ST_OK;
        state_nxt    = S_EMIT;
        unique case (act_r) inside
          ACT_PUSH: begin
            if (full) begin
              res_stat_nxt = ST_FULL;
            end else begin
              we          = 1'b1;
              cnt_nxt     = cnt_r + CW'(1);
              res_top_nxt = opnd_r;
            end
          end
          ACT_ADD, ACT_SUB: begin
            if (!has2) begin
              res_stat_nxt = ST_FEW;
            end else begin
              we          = 1'b1;
              waddr       = ra_next;
              wdata       = addsub;
              cnt_nxt     = cnt_r - CW'(1);
              res_top_nxt = addsub;
            end
          end
          ACT_MUL, ACT_DIV: begin
            if (!has2) begin
              res_stat_nxt = ST_FEW;
            end else if (act_r == ACT_DIV && rd_top_r == '0) begin
              res_stat_nxt = ST_DIVZERO;
            end else begin
              md_ctrl.start  = 1'b1;
              md_ctrl.is_div = (act_r == ACT_DIV);
              state_nxt      = S_ARITH;
            end
          end
          ACT_DROP: begin
            if (!has1) begin
              res_stat_nxt = ST_FEW;
            end else begin
              cnt_nxt     = cnt_r - CW'(1);
              res_top_nxt = has2 ? rd_next_r : '0;
            end
          end
          ACT_SWAP: begin
            if (!has2) begin
              res_stat_nxt = ST_FEW;
            end else begin
              we          = 1'b1;
              waddr       = ra_top;
              wdata       = rd_next_r;
              res_top_nxt = rd_next_r;
              state_nxt   = S_SWAP;
            end
          end
          ACT_DUP: begin
            if (!has1) begin
              res_stat_nxt = ST_FEW;
            end else if (full) begin
              res_stat_nxt = ST_FULL;
            end else begin
              we          = 1'b1;
              wdata       = rd_top_r;
              cnt_nxt     = cnt_r + CW'(1);
              res_top_nxt = rd_top_r;
            end
          end
          default: begin
            res_stat_nxt = ST_UNKNOWN;
          end
        endcase
      end
      S_SWAP: begin
        // Second half of the swap: old top goes one down
        we        = 1'b1;
        waddr     = ra_next;
        wdata     = rd_top_r;
        state_nxt = S_EMIT;
      end
      S_ARITH: begin
        if (md_done) begin
          we          = 1'b1;
          waddr       = ra_next;
          wdata       = md_result;
          cnt_nxt     = cnt_r - CW'(1);
          res_top_nxt = md_result;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_top_nxt   = OUT_TOP_W'(res_top_r);
          out_depth_nxt = OUT_DEPTH_W'(cnt_r);
          out_stat_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, count and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_fire) begin
      act_r  <= action_t'(in_ch.action);
      opnd_r <= DATA_WIDTH'(in_ch.operand_value);
    end
    res_top_r   <= res_top_nxt;
    res_stat_r  <= res_stat_nxt;
    out_top_r   <= out_top_nxt;
    out_depth_r <= out_depth_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.top_value   = out_top_r;
  assign out_ch.stack_depth = out_depth_r;
  assign out_ch.status      = out_stat_r;

endmodule

### rtl/rpn_sva.sv
// Port-level checks for the RPN stack calculator, bound to the top level.
// Depends on rpn_pkg for status codes and widths.
module rpn_sva (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [rpn_pkg::OUT_TOP_W-1:0]     out_top_value,
  input logic [rpn_pkg::OUT_DEPTH_W-1:0]   out_stack_depth,
  input logic [rpn_pkg::STATUS_W-1:0]      out_status
);
  import rpn_pkg::*;

  logic [OUT_DEPTH_W-1:0] last_depth_r;

  // Track the depth reported by the last delivered item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_depth_r <= '0;
    end else if (out_valid && out_ready) begin
      last_depth_r <= out_stack_depth;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_top_value)
      && $stable(out_stack_depth) && $stable(out_status))
    else $error("result changed while stalled");

  // A refused token leaves the depth unchanged
  a_err_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_stack_depth == last_depth_r)
    else $error("refused token changed stack depth");

  // An empty stack reports a zero top value
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stack_depth == '0 |-> out_top_value == '0)
    else $error("empty stack with non-zero top");

  // One item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item in flight");

endmodule

bind rpn_stack_calculator_unit rpn_sva u_rpn_sva (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_top_value   (out_ch.top_value),
  .out_stack_depth (out_ch.stack_depth),
  .out_status      (out_ch.status)
);
